@@ rtl/sac_pkg.sv @@
// Shared constants, types and codes of the set-associative write-through cache.
package sac_pkg;

  localparam int unsigned SETS       = 128;
  localparam int unsigned WAYS       = 8;
  localparam int unsigned LINE_BYTES = 64;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned OFS_W      = $clog2(LINE_BYTES);
  localparam int unsigned SET_W      = $clog2(SETS);
  localparam int unsigned WAY_W      = $clog2(WAYS);
  localparam int unsigned TAG_W      = ADDR_W - OFS_W - SET_W;
  localparam int unsigned WORD_W     = OFS_W - 3;
  localparam int unsigned FILL_WORDS = LINE_BYTES / 8;
  localparam int unsigned DADDR_W    = SET_W + WAY_W + WORD_W;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FETCH = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [2:0]  length;
    logic [31:0] write_data;
    logic [63:0] fill_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic [2:0]  mem_length;
  } rsp_t;

  typedef struct packed {
    logic init_done;
  } stat_t;

endpackage

@@ rtl/sac_if.sv @@
// Request and response channel interfaces of the cache.
interface sac_req_if;
  import sac_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sac_rsp_if;
  import sac_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sac_front.sv @@
// Front end: accepts request words, normalizes length and queues them for the back end.
module sac_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  sac_req_if.sink         req_i,
  sac_req_if.source       q_o,
  input  sac_pkg::stat_t  stat_i
);
  import sac_pkg::*;

  localparam int unsigned QDEPTH = 2;

  req_t        fifo_q [QDEPTH];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  req_t        item;

  // Take words only after the tag clear has finished and while there is room
  assign req_i.ready = stat_i.init_done && (cnt_q != 2'(QDEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign q_o.valid   = (cnt_q != 2'd0);
  assign q_o.data    = fifo_q[rd_q];
  assign pop         = q_o.valid && q_o.ready;

  // Clamp the length into 1..4
  always_comb begin
    item = req_i.data;
    if (req_i.data.length == 3'd0) begin
      item.length = 3'd1;
    end else if (req_i.data.length > 3'd4) begin
      item.length = 3'd4;
    end
  end

  // Advance pointers and count
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= item;
    end
  end

endmodule

@@ rtl/sac_back.sv @@
// Back end: tag/data arrays, byte-wise lookup, refill, write-through and flush sequencing.
module sac_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  sac_req_if.sink         q_i,
  sac_rsp_if.source       rsp_o,
  output sac_pkg::stat_t  stat_o
);
  import sac_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_LOOK, S_CMP, S_DATA, S_FILL, S_CLEAR
  } state_e;

  // Arrays
  logic [WAYS-1:0]             valid_mem [SETS];
  logic [WAYS-1:0][TAG_W-1:0]  tag_mem   [SETS];
  logic [63:0]                 data_mem  [2**DADDR_W];

  state_e             state_q, state_d;
  logic               is_wr_q, is_wr_d;
  logic [31:0]        addr_q, addr_d;
  logic [2:0]         len_q, len_d;
  logic [31:0]        wdata_q, wdata_d;
  logic [1:0]         idx_q, idx_d;
  logic [31:0]        gather_q, gather_d;
  logic [SET_W-1:0]   fill_set_q, fill_set_d;
  logic [TAG_W-1:0]   fill_tag_q, fill_tag_d;
  logic [WAY_W-1:0]   fill_way_q, fill_way_d;
  logic [WORD_W-1:0]  fill_cnt_q, fill_cnt_d;
  logic [15:0]        lfsr_q, lfsr_d;
  logic               rsf_q, rsf_d;
  logic [SET_W-1:0]   clr_q, clr_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic [WAYS-1:0]             valid_rd_q;
  logic [WAYS-1:0][TAG_W-1:0]  tag_rd_q;
  logic [63:0]                 data_rd_q;

  logic [31:0]        cur_a;
  logic [SET_W-1:0]   cur_set;
  logic [TAG_W-1:0]   cur_tag;
  logic [WORD_W-1:0]  cur_word;
  logic [2:0]         cur_byte;
  logic [WAYS-1:0]    hit_vec;
  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic               any_inv;
  logic [WAY_W-1:0]   inv_way;
  logic [15:0]        lfsr_nx;
  logic               last;
  logic               pop;
  logic [7:0]         wbyte;
  logic [31:0]        gather_n;
  logic [31:0]        wmask;

  logic               v_clr, v_we, v_val;
  logic [SET_W-1:0]   v_set;
  logic [WAY_W-1:0]   v_way;
  logic               t_we;
  logic               d_we;
  logic [DADDR_W-1:0] d_addr;
  logic [7:0]         d_be;
  logic [63:0]        d_wdata;

  assign stat_o.init_done = (state_q != S_INIT);
  assign q_i.ready   = ((state_q == S_IDLE) || (state_q == S_FILL)) && !rsp_valid_q;
  assign pop         = q_i.valid && q_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Decode current byte address
  assign cur_a    = addr_q + {30'd0, idx_q};
  assign cur_set  = cur_a[OFS_W +: SET_W];
  assign cur_tag  = cur_a[ADDR_W-1 -: TAG_W];
  assign cur_word = cur_a[3 +: WORD_W];
  assign cur_byte = cur_a[2:0];
  assign last     = ({1'b0, idx_q} == (len_q - 3'd1));
  assign lfsr_nx  = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign wbyte    = wdata_q[8*idx_q +: 8];
  assign gather_n = gather_q | (32'(data_rd_q[8*cur_byte +: 8]) << (8*idx_q));

  // Compare tags and pick hit and victim ways
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    any_inv = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid_rd_q[w] && (tag_rd_q[w] == cur_tag);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid_rd_q[w]) begin
        inv_way = WAY_W'(w);
        any_inv = 1'b1;
      end
    end
    hit = |hit_vec;
  end

  // Mask unused write bytes
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      wmask[8*b +: 8] = (3'(b) < len_q) ? 8'hFF : 8'h00;
    end
  end

  // Sequence one request
  always_comb begin
    state_d     = state_q;
    is_wr_d     = is_wr_q;
    addr_d      = addr_q;
    len_d       = len_q;
    wdata_d     = wdata_q;
    idx_d       = idx_q;
    gather_d    = gather_q;
    fill_set_d  = fill_set_q;
    fill_tag_d  = fill_tag_q;
    fill_way_d  = fill_way_q;
    fill_cnt_d  = fill_cnt_q;
    lfsr_d      = lfsr_q;
    rsf_d       = rsf_q;
    clr_d       = clr_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    v_clr       = 1'b0;
    v_we        = 1'b0;
    v_val       = 1'b0;
    v_set       = cur_set;
    v_way       = '0;
    t_we        = 1'b0;
    d_we        = 1'b0;
    d_addr      = {cur_set, hit_way, cur_word};
    d_be        = 8'h01 << cur_byte;
    d_wdata     = {8{wbyte}};
    unique case (state_q)
      S_INIT, S_CLEAR: begin
        v_clr = 1'b1;
        v_set = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == SET_W'(SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          addr_d   = q_i.data.address;
          len_d    = q_i.data.length;
          wdata_d  = q_i.data.write_data;
          idx_d    = 2'd0;
          gather_d = '0;
          case (q_i.data.op)
            OP_READ: begin
              rsf_d   = 1'b1;
              is_wr_d = 1'b0;
              state_d = S_LOOK;
            end
            OP_WRITE: begin
              is_wr_d = 1'b1;
              state_d = S_LOOK;
            end
            OP_FLUSH: begin
              rsp_d       = '0;
              rsp_d.kind  = KIND_DONE;
              rsp_valid_d = 1'b1;
              if (rsf_q) begin
                rsf_d   = 1'b0;
                clr_d   = '0;
                state_d = S_CLEAR;
              end
            end
            default: ;  // stray fill word: drop
          endcase
        end
      end
      S_LOOK: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (is_wr_q) begin
          d_we = hit;
          if (last) begin
            rsp_d             = '0;
            rsp_d.kind        = KIND_WRITE;
            rsp_d.mem_address = addr_q;
            rsp_d.mem_data    = wdata_q & wmask;
            rsp_d.mem_length  = len_q;
            rsp_valid_d       = 1'b1;
            state_d           = S_IDLE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = S_LOOK;
          end
        end else if (hit) begin
          state_d = S_DATA;
        end else begin
          // Miss: pick victim, invalidate it, request the line
          if (any_inv) begin
            fill_way_d = inv_way;
          end else begin
            lfsr_d     = lfsr_nx;
            fill_way_d = lfsr_nx[WAY_W-1:0];
          end
          v_we              = 1'b1;
          v_way             = fill_way_d;
          fill_set_d        = cur_set;
          fill_tag_d        = cur_tag;
          fill_cnt_d        = '0;
          rsp_d             = '0;
          rsp_d.kind        = KIND_FETCH;
          rsp_d.mem_address = {cur_a[ADDR_W-1:OFS_W], OFS_W'(0)};
          rsp_valid_d       = 1'b1;
          state_d           = S_FILL;
        end
      end
      S_DATA: begin
        gather_d = gather_n;
        if (last) begin
          rsp_d           = '0;
          rsp_d.kind      = KIND_READ;
          rsp_d.read_data = gather_n;
          rsp_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_LOOK;
        end
      end
      S_FILL: begin
        if (pop && (q_i.data.op == OP_FILL)) begin
          d_we       = 1'b1;
          d_addr     = {fill_set_q, fill_way_q, fill_cnt_q};
          d_be       = 8'hFF;
          d_wdata    = q_i.data.fill_word;
          fill_cnt_d = fill_cnt_q + 1'b1;
          if (fill_cnt_q == WORD_W'(FILL_WORDS - 1)) begin
            t_we     = 1'b1;
            v_we     = 1'b1;
            v_val    = 1'b1;
            v_set    = fill_set_q;
            v_way    = fill_way_q;
            idx_d    = 2'd0;
            gather_d = '0;
            state_d  = S_LOOK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      is_wr_q     <= 1'b0;
      addr_q      <= '0;
      len_q       <= 3'd1;
      wdata_q     <= '0;
      idx_q       <= '0;
      gather_q    <= '0;
      fill_set_q  <= '0;
      fill_tag_q  <= '0;
      fill_way_q  <= '0;
      fill_cnt_q  <= '0;
      lfsr_q      <= 16'hACE1;
      rsf_q       <= 1'b0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      is_wr_q     <= is_wr_d;
      addr_q      <= addr_d;
      len_q       <= len_d;
      wdata_q     <= wdata_d;
      idx_q       <= idx_d;
      gather_q    <= gather_d;
      fill_set_q  <= fill_set_d;
      fill_tag_q  <= fill_tag_d;
      fill_way_q  <= fill_way_d;
      fill_cnt_q  <= fill_cnt_d;
      lfsr_q      <= lfsr_d;
      rsf_q       <= rsf_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  // Valid bits: clear a whole set or write one way
  always_ff @(posedge clk_i) begin
    if (v_clr) begin
      valid_mem[v_set] <= '0;
    end else if (v_we) begin
      valid_mem[v_set][v_way] <= v_val;
    end
    valid_rd_q <= valid_mem[cur_set];
  end

  // Tags
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tag_mem[fill_set_q][fill_way_q] <= fill_tag_q;
    end
    tag_rd_q <= tag_mem[cur_set];
  end

  // Line data with byte enables
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 8; b++) begin
      if (d_we && d_be[b]) begin
        data_mem[d_addr][8*b +: 8] <= d_wdata[8*b +: 8];
      end
    end
    data_rd_q <= data_mem[{cur_set, hit_way, cur_word}];
  end

  // No word taken during a clear sweep
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_INIT) || (state_q == S_CLEAR)) |-> !pop)
    else $error("word taken during clear sweep");

  // A taken word always finds the result slot free
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !rsp_valid_q)
    else $error("word taken while result pending");

  // LFSR never locks up
  a_lfsr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != 16'd0)
    else $error("victim LFSR reached zero");

  // A fetch request leaves the sequencer waiting for fill words
  a_fetch_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rsp_valid_q) && (rsp_q.kind == KIND_FETCH)) |-> (state_q == S_FILL))
    else $error("fetch issued without entering refill");

endmodule

@@ rtl/set_assoc_write_through_cache_top.sv @@
// Top level of the set-associative write-through cache.
// Usage:
//   req_i carries request words (read, write, line fill word, flush) with
//   valid/ready; a word is accepted when both are high. rsp_o returns result
//   words: read data, memory write, line fetch request or flush done; a read
//   that misses returns fetch requests before its data. Requests queue in a
//   two-entry buffer, so the front keeps taking words while a result waits for
//   rsp_o.ready. A read hit steps through tag read, compare and data read for
//   each byte; a write steps through tag read and compare for each byte. A miss
//   emits a fetch request and completes after the eighth fill word, then
//   replays the lookup. A flush answers with a done word and, when lines must
//   be dropped, sweeps all 128 sets of the valid array.
//   Reset: all 128 sets of the valid array are cleared first; req_i.ready
//   stays low until it ends. While rsp_o is stalled, the back end holds its
//   result and takes no further word; the queue fills and then drops ready.
module set_assoc_write_through_cache_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  sac_req_if.sink   req_i,
  sac_rsp_if.source rsp_o
);
  import sac_pkg::*;

  stat_t stat;

  sac_req_if q ();

  sac_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .q_o    (q),
    .stat_i (stat)
  );

  sac_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q),
    .rsp_o  (rsp_o),
    .stat_o (stat)
  );

endmodule

@@ dv/set_assoc_write_through_cache_top_tb.sv @@
// Testbench of the set-associative write-through cache: directed and random words, scoreboard.
module set_assoc_write_through_cache_top_tb;
  import sac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SLOT_CNT    = SETS * WAYS;

  logic clk_i;
  logic rst_ni;

  sac_req_if req_if ();
  sac_rsp_if rsp_if ();

  set_assoc_write_through_cache_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Cache image kept beside the block
  bit          img_valid [SLOT_CNT];
  bit [18:0]   img_tag   [SLOT_CNT];
  bit [7:0]    img_byte  [SLOT_CNT*LINE_BYTES];
  bit [15:0]   victim_lfsr;
  bit          read_since_flush;
  bit [31:0]   pend_addr;
  bit [2:0]    pend_len;
  int unsigned fill_cnt;
  int unsigned fill_way;
  bit [25:0]   fill_line;
  bit          refill_busy;

  rsp_t        expected_rsp [$];
  int unsigned fail_cnt;
  int unsigned sent_cnt;
  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned quiet_cycles;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int find_way(bit [31:0] a);
    int s;
    for (int w = 0; w < WAYS; w++) begin
      s = a[12:6] * WAYS + w;
      if (img_valid[s] && img_tag[s] == a[31:13]) return w;
    end
    return -1;
  endfunction

  // Walk the pending read byte by byte; miss starts a refill
  function automatic rsp_t gather_read();
    rsp_t        r;
    bit [31:0]   a;
    bit [31:0]   gath;
    int          w;
    int          v;
    int          s;
    bit [15:0]   l;
    r = '0;
    gath = '0;
    for (int i = 0; i < pend_len; i++) begin
      a = pend_addr + i;
      w = find_way(a);
      if (w < 0) begin
        v = -1;
        for (int k = 0; k < WAYS; k++)
          if (!img_valid[a[12:6] * WAYS + k]) v = k;
        if (v < 0) begin
          l = victim_lfsr;
          victim_lfsr = {l[0] ^ l[2] ^ l[3] ^ l[5], l[15:1]};
          v = victim_lfsr % WAYS;
        end
        img_valid[a[12:6] * WAYS + v] = 1'b0;
        fill_way    = v;
        fill_line   = a[31:6];
        fill_cnt    = 0;
        refill_busy = 1'b1;
        r.kind        = KIND_FETCH;
        r.mem_address = {a[31:6], 6'd0};
        return r;
      end
      s = a[12:6] * WAYS + w;
      gath |= 32'(img_byte[s * LINE_BYTES + a[5:0]]) << (8 * i);
    end
    r.kind      = KIND_READ;
    r.read_data = gath;
    return r;
  endfunction

  // Advance the image by one accepted word and queue its result
  function automatic void predict_word(req_t w);
    rsp_t      r;
    bit [2:0]  len;
    bit [31:0] a;
    int        s;
    int        hw;
    len = (w.length == 0) ? 3'd1 : (w.length > 4) ? 3'd4 : w.length;
    r = '0;
    if (refill_busy) begin
      if (w.op != OP_FILL) return;
      s = fill_line[6:0] * WAYS + fill_way;
      for (int b = 0; b < 8; b++)
        img_byte[s * LINE_BYTES + fill_cnt * 8 + b] = w.fill_word[8*b +: 8];
      fill_cnt++;
      if (fill_cnt < FILL_WORDS) return;
      img_valid[s] = 1'b1;
      img_tag[s]   = fill_line[25:7];
      fill_cnt     = 0;
      refill_busy  = 1'b0;
      expected_rsp.push_back(gather_read());
      return;
    end
    case (w.op)
      OP_READ: begin
        read_since_flush = 1'b1;
        pend_addr = w.address;
        pend_len  = len;
        expected_rsp.push_back(gather_read());
      end
      OP_WRITE: begin
        for (int i = 0; i < len; i++) begin
          a  = w.address + i;
          hw = find_way(a);
          if (hw >= 0) img_byte[(a[12:6] * WAYS + hw) * LINE_BYTES + a[5:0]] =
              w.write_data[8*i +: 8];
        end
        r.kind        = KIND_WRITE;
        r.mem_address = w.address;
        r.mem_data    = (len == 4) ? w.write_data : w.write_data & ((32'd1 << (8 * len)) - 1);
        r.mem_length  = len;
        expected_rsp.push_back(r);
      end
      OP_FLUSH: begin
        if (read_since_flush) begin
          foreach (img_valid[i]) img_valid[i] = 1'b0;
          read_since_flush = 1'b0;
        end
        r.kind = KIND_DONE;
        expected_rsp.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Drive one word at the falling edge, hold until accepted
  task automatic send_word(req_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk_i); while (!req_if.ready);
    predict_word(w);
    sent_cnt++;
  endtask

  function automatic req_t make_word(op_e op, bit [31:0] addr, bit [2:0] len);
    req_t w;
    w.op         = op;
    w.address    = addr;
    w.length     = len;
    w.write_data = $urandom();
    w.fill_word  = {$urandom(), $urandom()};
    return w;
  endfunction

  // Read, then feed fill words until no refill is pending; noise optional
  task automatic read_line(bit [31:0] addr, bit [2:0] len, int unsigned noise_pct);
    send_word(make_word(OP_READ, addr, len));
    while (refill_busy) begin
      if ($urandom_range(99) < noise_pct)
        send_word(make_word(op_e'($urandom_range(1) ? OP_WRITE : OP_READ), $urandom(), 3'd2));
      else
        send_word(make_word(OP_FILL, $urandom(), 3'($urandom_range(7))));
    end
  endtask

  // Mostly a few busy sets with more tags than ways; sometimes anywhere
  function automatic bit [31:0] pick_addr();
    if ($urandom_range(9) == 0) return $urandom();
    return {19'($urandom_range(11)), 7'($urandom_range(3)), 6'($urandom_range(63))};
  endfunction

  // Sample results at the rising edge and compare
  always @(posedge clk_i) begin
    rsp_t e;
    rsp_t g;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      g = rsp_if.data;
      if (expected_rsp.size() == 0) begin
        $error("unexpected result word kind %0d", g.kind);
        fail_cnt++;
      end else begin
        e = expected_rsp.pop_front();
        if (g.kind != e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, g.kind); fail_cnt++;
        end
        if (g.read_data != e.read_data) begin
          $error("read_data: expected %h, got %h", e.read_data, g.read_data); fail_cnt++;
        end
        if (g.mem_address != e.mem_address) begin
          $error("mem_address: expected %h, got %h", e.mem_address, g.mem_address);
          fail_cnt++;
        end
        if (g.mem_data != e.mem_data) begin
          $error("mem_data: expected %h, got %h", e.mem_data, g.mem_data); fail_cnt++;
        end
        if (g.mem_length != e.mem_length) begin
          $error("mem_length: expected %0d, got %0d", e.mem_length, g.mem_length);
          fail_cnt++;
        end
      end
    end
  end

  // Randomly stall the result channel
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // End the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_miss_and_hit();
    read_line(32'h0000_0000, 3'd1, 0);
    read_line(32'h0000_0001, 3'd4, 0);
    send_word(make_word(OP_FILL, '0, 3'd1));
  endtask

  task automatic test_spans_and_wrap();
    read_line(32'h0000_007E, 3'd4, 0);
    read_line(32'hFFFF_FFFE, 3'd4, 0);
    read_line(32'h0000_0010, 3'd0, 0);
    read_line(32'h0000_0011, 3'd7, 0);
  endtask

  task automatic test_writes();
    send_word(make_word(OP_WRITE, 32'h0000_0003, 3'd2));
    send_word(make_word(OP_WRITE, 32'h1234_5600, 3'd5));
    read_line(32'h0000_0003, 3'd2, 0);
    send_word(make_word(OP_WRITE, 32'hFFFF_FFFF, 3'd0));
  endtask

  task automatic test_busy_ignore();
    read_line(32'h0000_4000, 3'd3, 50);
    read_line(32'h0000_6000, 3'd1, 50);
  endtask

  // Fill all ways of set zero and go past them to reach the LFSR choice
  task automatic test_replacement();
    for (int t = 0; t < 10; t++) read_line({19'(t + 20), 7'd0, 6'd5}, 3'd1, 0);
  endtask

  task automatic test_flush();
    send_word(make_word(OP_FLUSH, '0, 3'd1));
    send_word(make_word(OP_FLUSH, '0, 3'd1));
    read_line(32'h0000_0000, 3'd1, 0);
  endtask

  task automatic test_random(int unsigned n, int unsigned sidle, int unsigned rstall);
    int unsigned stop_at;
    int unsigned r;
    send_idle_pct = sidle;
    rsp_stall_pct = rstall;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      r = $urandom_range(99);
      if (r < 50)      read_line(pick_addr(), 3'($urandom_range(7)), 8);
      else if (r < 85) send_word(make_word(OP_WRITE, pick_addr(), 3'($urandom_range(7))));
      else if (r < 89) send_word(make_word(OP_FLUSH, $urandom(), 3'($urandom_range(7))));
      else if (r < 92) send_word(make_word(OP_FILL, $urandom(), 3'($urandom_range(7))));
      else             read_line($urandom(), 3'($urandom_range(7)), 0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    rsp_if.ready  = 1'b0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    fail_cnt      = 0;
    sent_cnt      = 0;
    quiet_cycles  = 0;
    foreach (img_valid[i]) img_valid[i] = 1'b0;
    victim_lfsr      = 16'hACE1;
    read_since_flush = 1'b0;
    refill_busy      = 1'b0;
    fill_cnt         = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_miss_and_hit();
    test_spans_and_wrap();
    test_writes();
    test_busy_ignore();
    test_replacement();
    test_flush();
    test_random(245, 0, 0);
    test_random(245, 61, 0);
    test_random(245, 0, 61);
    test_random(245, 31, 31);

    // Drain outstanding results, then let the block settle
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
